FILE: sv/lkvd_pkg.sv
// shared types, codes and constants of the length-prefixed key/value deframer
package lkvd_pkg;

  // parse phase of the current frame
  typedef enum logic [1:0] {
    PH_LEN_HI = 2'd0,
    PH_LEN_LO = 2'd1,
    PH_BODY   = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // frame status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_TRAIL = 2'd2;

  // register map
  localparam int unsigned PADDR_W = 3;
  localparam logic [PADDR_W-3:0] REG_TWO_STRINGS = '0;
  localparam logic TWO_STRINGS_RESET = 1'b1;

  // result queue depth default
  localparam int unsigned OUTQ_DEPTH_DEF = 4;

  // parser state carried from item to item
  typedef struct packed {
    phase_e      phase;
    logic        str_idx;
    logic [15:0] bytes_left;
    logic [7:0]  len_hi;
    logic        extra;
  } dfr_state_t;

  // one result item
  typedef struct packed {
    logic [1:0] kind;
    logic       which_string;
    logic [7:0] payload;
    logic       string_done;
    logic [1:0] status;
    logic       run_last;
  } result_t;

  // step outputs toward the result queue
  typedef struct packed {
    logic    vld0;
    result_t res0;
    logic    vld1;
    result_t res1;
  } step_out_t;

endpackage

FILE: sv/lkvd_step.sv
// per-byte parse step: next state and up to two results
module lkvd_step import lkvd_pkg::*; (
  input  dfr_state_t state_i,
  input  logic [7:0] data_byte_i,
  input  logic       frame_end_i,
  input  logic       two_strings_i,
  output dfr_state_t state_o,
  output step_out_t  step_o
);

  dfr_state_t  mid;
  logic [15:0] len;
  logic [15:0] dec;
  logic        fin;
  logic [1:0]  st;

  always_comb begin
    mid          = state_i;
    len          = {state_i.len_hi, data_byte_i};
    dec          = state_i.bytes_left - 16'd1;
    fin          = 1'b0;
    step_o       = '0;
    step_o.res0.which_string = state_i.str_idx;

    // phase-specific work
    case (state_i.phase)
      PH_LEN_HI: begin
        mid.len_hi = data_byte_i;
        mid.phase  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (len == 16'd0) begin
          step_o.vld0             = 1'b1;
          step_o.res0.kind        = KIND_EMPTY;
          step_o.res0.string_done = 1'b1;
          fin                     = 1'b1;
        end else begin
          mid.bytes_left = len;
          mid.phase      = PH_BODY;
        end
      end
      PH_BODY: begin
        if (state_i.bytes_left == 16'd0) begin
          mid.phase = PH_DONE;
          mid.extra = 1'b1;
        end else begin
          mid.bytes_left          = dec;
          step_o.vld0             = 1'b1;
          step_o.res0.kind        = KIND_PAYLOAD;
          step_o.res0.payload     = data_byte_i;
          step_o.res0.string_done = (dec == 16'd0);
          fin                     = (dec == 16'd0);
        end
      end
      default: begin
        mid.extra = 1'b1;
      end
    endcase

    // string complete: value string follows or frame is done
    if (fin) begin
      mid.bytes_left = 16'd0;
      if (!state_i.str_idx && two_strings_i) begin
        mid.str_idx = 1'b1;
        mid.phase   = PH_LEN_HI;
      end else begin
        mid.phase = PH_DONE;
      end
    end

    // frame status on the final byte
    if (mid.phase != PH_DONE) begin
      st = ST_TRUNC;
    end else if (mid.extra) begin
      st = ST_TRAIL;
    end else begin
      st = ST_OK;
    end
    step_o.res0.run_last = !frame_end_i;
    step_o.vld1          = frame_end_i;
    step_o.res1.kind     = KIND_STATUS;
    step_o.res1.status   = st;
    step_o.res1.run_last = 1'b1;

    if (frame_end_i) begin
      state_o       = '0;
      state_o.phase = PH_LEN_HI;
    end else begin
      state_o = mid;
    end
  end

endmodule

FILE: sv/lkvd_outq.sv
// result queue: up to two pushes and one pop per cycle
module lkvd_outq import lkvd_pkg::*; #(
  parameter int unsigned DEPTH = OUTQ_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  step_out_t push_i,
  input  logic      push_en_i,
  output logic      room2_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output result_t   head_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  result_t         mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr1;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            pop;
  logic [1:0]      npush;
  result_t         p0;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // push selection: first valid result goes first
  always_comb begin
    p0       = push_i.vld0 ? push_i.res0 : push_i.res1;
    npush    = push_en_i ? (2'(push_i.vld0) + 2'(push_i.vld1)) : 2'd0;
    pop      = out_valid_o && out_ready_i;
    wr_ptr1  = inc(wr_ptr_q);
    wr_ptr_d = (npush == 2'd2) ? inc(wr_ptr1) : (npush == 2'd1) ? wr_ptr1 : wr_ptr_q;
    rd_ptr_d = pop ? inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CW'(npush) - CW'(pop);
  end

  assign room2_o     = (cnt_q <= CW'(DEPTH - 2));
  assign out_valid_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (npush != 2'd0) begin
      mem_q[wr_ptr_q] <= p0;
    end
    if (npush == 2'd2) begin
      mem_q[wr_ptr1] <= push_i.res1;
    end
  end

  // no push beyond free space
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW'(npush) <= CW'(DEPTH) - cnt_q + CW'(pop)))
    else $error("result queue overflow");

  // fill count bounded by depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("result queue count out of range");

  // an empty or full count means the pointers are equal
  a_ptr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CW'(DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("result queue pointers disagree with count");

endmodule

FILE: sv/length_prefixed_kv_deframer_unit.sv
// top level of the length-prefixed key/value deframer
//
// Input channel: one frame byte per item (data_byte_i) with frame_end_i on the
// frame's last byte, handshaked by in_valid_i / in_ready_o.
// Output channel: result items (kind, which_string, payload, string_done,
// status, run_last) handshaked by out_valid_o / out_ready_i. Each byte gives
// zero, one or two results; run_last marks the last result of a byte.
// Each accepted byte is parsed in the cycle it is accepted; its results enter
// a result queue (OUTQ_DEPTH, four by default) and are offered from the next
// cycle on. A new byte is taken every cycle while the queue has room for two
// results; the output side drains one result per cycle while out_ready_i is
// high, which sets the sustained rate for bytes that cause two results.
// Configuration: APB register two_strings at address 0 (0 key only, 1 key
// then value), write it only while the block is idle.
// Reset clears the parser to expect a key length and sets two_strings to 1;
// the result queue empties. When the receiver stalls, results stay in the
// queue and in_ready_o drops once fewer than two entries are free.
module length_prefixed_kv_deframer_unit import lkvd_pkg::*; #(
  parameter int unsigned OUTQ_DEPTH = OUTQ_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               frame_end_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic               which_string_o,
  output logic [7:0]         payload_o,
  output logic               string_done_o,
  output logic [1:0]         status_o,
  output logic               run_last_o
);

  dfr_state_t state_q, state_d;
  step_out_t  step;
  result_t    head;
  logic       two_strings_q;
  logic       in_acc;
  logic       reg_hit;

  // configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_TWO_STRINGS);
  assign prdata  = reg_hit ? {31'd0, two_strings_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      two_strings_q <= TWO_STRINGS_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      two_strings_q <= pwdata[0];
    end
  end

  // parse step
  lkvd_step u_step (
    .state_i       (state_q),
    .data_byte_i   (data_byte_i),
    .frame_end_i   (frame_end_i),
    .two_strings_i (two_strings_q),
    .state_o       (state_d),
    .step_o        (step)
  );

  assign in_acc = in_valid_i && in_ready_o;

  // parser state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_LEN_HI, str_idx: 1'b0, bytes_left: 16'd0, len_hi: 8'd0,
                   extra: 1'b0};
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  // result queue
  lkvd_outq #(
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .push_en_i   (in_acc),
    .room2_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign kind_o         = head.kind;
  assign which_string_o = head.which_string;
  assign payload_o      = head.payload;
  assign string_done_o  = head.string_done;
  assign status_o       = head.status;
  assign run_last_o     = head.run_last;

  // frame end returns the parser to its start
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && frame_end_i) |=>
      (state_q.phase == PH_LEN_HI && !state_q.str_idx && !state_q.extra))
    else $error("parser not cleared after frame end");

  // body phase always has bytes due
  a_body_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_BODY) |-> (state_q.bytes_left != 16'd0))
    else $error("body phase with no bytes due");

  // outside the body no count is held
  a_len_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase != PH_BODY) |-> (state_q.bytes_left == 16'd0))
    else $error("stale byte count outside body");

endmodule

FILE: tb/sv/length_prefixed_kv_deframer_unit_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the length-prefixed key/value deframer unit
module length_prefixed_kv_deframer_unit_tb;
  import lkvd_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam logic [PADDR_W-1:0] TWO_STRINGS_ADDR = {REG_TWO_STRINGS, 2'b00};

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  // configuration port
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;

  // byte and result channels
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i = '0;
  logic       frame_end_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] kind_o;
  logic       which_string_o;
  logic [7:0] payload_o;
  logic       string_done_o;
  logic [1:0] status_o;
  logic       run_last_o;

  length_prefixed_kv_deframer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .frame_end_i   (frame_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .which_string_o(which_string_o),
    .payload_o     (payload_o),
    .string_done_o (string_done_o),
    .status_o      (status_o),
    .run_last_o    (run_last_o)
  );

  // parser copy kept by the testbench
  phase_e      ph;
  logic        str_idx;
  logic [15:0] body_left;
  logic [7:0]  len_hi;
  logic        extra;
  logic        cfg_two_strings;
  result_t     deframed_q[$];

  // run bookkeeping
  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned bytes_sent   = 0;
  int unsigned frames_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned status_seen[3];
  bit          idle_on      = 1'b1;
  int unsigned stall_left   = 0;
  logic        sel_two_strings;
  logic [7:0]  frame_q[$];

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic clear_frame_state();
    ph        = PH_LEN_HI;
    str_idx   = 1'b0;
    body_left = '0;
    len_hi    = '0;
    extra     = 1'b0;
  endtask

  // a string is complete: the current setting decides if a value follows
  task automatic close_string();
    if (str_idx == 1'b0 && cfg_two_strings) begin
      str_idx = 1'b1;
      ph      = PH_LEN_HI;
    end else begin
      ph = PH_DONE;
    end
    body_left = '0;
  endtask

  // work out the results one accepted byte causes
  task automatic deframe_byte(input logic [7:0] b, input logic is_end);
    result_t     body_res;
    result_t     st_res;
    logic        have_body;
    logic [15:0] len;
    body_res  = '0;
    st_res    = '0;
    have_body = 1'b0;
    case (ph)
      PH_LEN_HI: begin
        len_hi = b;
        ph     = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len = {len_hi, b};
        if (len == 16'd0) begin
          body_res.kind         = KIND_EMPTY;
          body_res.which_string = str_idx;
          body_res.string_done  = 1'b1;
          have_body             = 1'b1;
          close_string();
        end else begin
          body_left = len;
          ph        = PH_BODY;
        end
      end
      PH_BODY: begin
        if (body_left == 16'd0) begin
          ph    = PH_DONE;
          extra = 1'b1;
        end else begin
          body_left             = body_left - 16'd1;
          body_res.kind         = KIND_PAYLOAD;
          body_res.which_string = str_idx;
          body_res.payload      = b;
          body_res.string_done  = (body_left == 16'd0);
          have_body             = 1'b1;
          if (body_left == 16'd0) close_string();
        end
      end
      default: extra = 1'b1;
    endcase
    if (is_end) begin
      st_res.kind = KIND_STATUS;
      if (ph != PH_DONE) st_res.status = ST_TRUNC;
      else if (extra) st_res.status = ST_TRAIL;
      else st_res.status = ST_OK;
      st_res.run_last = 1'b1;
      status_seen[st_res.status]++;
      if (have_body) deframed_q.insert(deframed_q.size(), body_res);
      deframed_q.insert(deframed_q.size(), st_res);
      clear_frame_state();
    end else if (have_body) begin
      body_res.run_last = 1'b1;
      deframed_q.insert(deframed_q.size(), body_res);
    end
  endtask

  // check results, predict accepted bytes, track register writes
  always @(posedge clk_i) begin : monitor
    result_t got;
    result_t want;
    bit      moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        results_seen++;
        got = '{kind_o, which_string_o, payload_o, string_done_o, status_o, run_last_o};
        if (deframed_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d str %0d byte %02h done %0d st %0d last %0d",
                                    got.kind, got.which_string, got.payload, got.string_done,
                                    got.status, got.run_last));
        end else begin
          want = deframed_q.pop_front();
          if (got !== want) begin
            report_mismatch($sformatf({"expected kind %0d str %0d byte %02h done %0d st %0d last %0d,",
                                       " got kind %0d str %0d byte %02h done %0d st %0d last %0d"},
                                      want.kind, want.which_string, want.payload, want.string_done,
                                      want.status, want.run_last, got.kind, got.which_string,
                                      got.payload, got.string_done, got.status, got.run_last));
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        moved = 1'b1;
        deframe_byte(data_byte_i, frame_end_i);
      end
      if (psel && penable && pwrite && pready) begin
        moved = 1'b1;
        if (paddr == TWO_STRINGS_ADDR) cfg_two_strings = pwdata[0];
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // receiver with random stall bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // progress watchdog
  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("watchdog: nothing moved for %0d cycles, %0d results still due",
             IDLE_LIMIT, deframed_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // offer one byte, with an occasional gap first, and wait for it to go in
  task automatic send_byte(input logic [7:0] b, input logic is_end);
    int unsigned gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    frame_end_i <= is_end;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  // stop offering bytes and let every due result come out
  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write two_strings while idle, then read it back
  task automatic write_two_strings(input logic v);
    wait_results_drained();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TWO_STRINGS_ADDR;
    pwdata  <= {31'b0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {31'b0, v})
      report_mismatch($sformatf("two_strings read back %08h, expected %0d", prdata, v));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    sel_two_strings = v;
  endtask

  function automatic int unsigned rand_str_len();
    int unsigned r;
    r = $urandom_range(0, 39);
    if (r < 24) return $urandom_range(0, 4);
    else if (r < 39) return $urandom_range(5, 20);
    else return $urandom_range(250, 270);
  endfunction

  task automatic add_string(input int unsigned len);
    frame_q.insert(frame_q.size(), len[15:8]);
    frame_q.insert(frame_q.size(), len[7:0]);
    repeat (len) frame_q.insert(frame_q.size(), 8'($urandom_range(0, 255)));
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
    frames_sent++;
  endtask

  // mostly well-formed frames, the rest cut short, padded, miscounted or noise
  task automatic run_random_frames(input int unsigned n_bytes);
    int unsigned first;
    int unsigned pick;
    int unsigned cut;
    first = bytes_sent;
    while (bytes_sent - first < n_bytes) begin
      pick = $urandom_range(0, 9);
      if (pick == 9) begin
        repeat ($urandom_range(1, 8)) frame_q.insert(frame_q.size(), 8'($urandom_range(0, 255)));
      end else if (pick == 8) begin
        add_string(rand_str_len());
        if (!sel_two_strings) add_string(rand_str_len());
      end else begin
        add_string(rand_str_len());
        if (sel_two_strings) add_string(rand_str_len());
        if (pick == 6 && frame_q.size() > 1) begin
          cut = $urandom_range(1, frame_q.size() - 1);
          while (frame_q.size() > cut) frame_q.delete(frame_q.size() - 1);
        end else if (pick == 7) begin
          repeat ($urandom_range(1, 3)) frame_q.insert(frame_q.size(), 8'($urandom_range(0, 255)));
        end
      end
      send_frame();
    end
  endtask

  // key then value with the reset setting, one empty string each way
  task automatic test_key_value_reset();
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // key only: empty key, early ends, a byte past the key
  task automatic test_key_only_cases();
    write_two_strings(1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    // frame ends on the high length byte
    send_byte(8'h01, 1'b1);
    // largest length, frame ends inside the body
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hAA, 1'b1);
    // trailing byte after the only string
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b1);
  endtask

  // setting changed inside a key: the new value decides the frame layout
  task automatic test_midframe_setting();
    write_two_strings(1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h11, 1'b0);
    write_two_strings(1'b0);
    send_byte(8'h22, 1'b1);
  endtask

  task automatic test_random_key_value();
    write_two_strings(1'b1);
    run_random_frames(420);
  endtask

  task automatic test_random_key_only();
    write_two_strings(1'b0);
    run_random_frames(350);
  endtask

  // last part at full rate with no gaps or stalls
  task automatic test_random_full_rate();
    wait_results_drained();
    idle_on = 1'b0;
    write_two_strings(1'b1);
    run_random_frames(360);
  endtask

  initial begin
    cfg_two_strings = TWO_STRINGS_RESET;
    sel_two_strings = TWO_STRINGS_RESET;
    clear_frame_state();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_key_value_reset();
    test_key_only_cases();
    test_midframe_setting();
    test_random_key_value();
    test_random_key_only();
    test_random_full_rate();

    wait_results_drained();
    if (deframed_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", deframed_q.size()));
    $display("run covered %0d frames, %0d bytes and %0d results in both string modes",
             frames_sent, bytes_sent, results_seen);
    $display("frame status counts: ok %0d, truncated %0d, trailing %0d; %0d mismatches",
             status_seen[ST_OK], status_seen[ST_TRUNC], status_seen[ST_TRAIL], mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
